// ===== hw/rtl/dwau_pkg.sv =====
package dwau_pkg;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned WIDE_W = ADDR_W + 1;

  // boundary on the inverted index that picks the upward check for subtract
  localparam logic [WIDE_W-1:0] SUB_SPLIT = 17'h07FFF;

  typedef enum logic [2:0] {
    OP_WR_ADDR   = 3'd0,
    OP_WR_WRAP   = 3'd1,
    OP_WR_INDEX  = 3'd2,
    OP_INC       = 3'd3,
    OP_DEC       = 3'd4,
    OP_ADD_INDEX = 3'd5,
    OP_SUB_INDEX = 3'd6
  } op_t;

  // bit just above the top of the wrap window: (wrap | 1) << 1
  function automatic logic [WIDE_W-1:0] top_bit(input logic [ADDR_W-1:0] wrap);
    top_bit = {wrap[ADDR_W-1:1], 1'b1, 1'b0};
  endfunction

endpackage

// ===== hw/rtl/dsp_wrapping_address_unit.sv =====
// circular address generation unit with NUM_SETS sets of address, wrap and index registers
//
// input channel: a transaction is taken at a rising edge with start high and busy low;
//   in_operation picks a register write (address, wrap, index) or an address step
//   (increment, decrement, add index, subtract index) on the set named by in_reg_sel
// result channel: out_valid is high for one cycle with out_address_out, the address
//   of the selected set after the step; a set beyond NUM_SETS gives zero
// order: the transaction lands in the input register at its accept edge, the
//   step logic and register file update run in the next cycle, and the result
//   is shown in the cycle after that
// throughput: one transaction per cycle; register file writes land at the same
//   edge as the result, so back to back transactions on one set see each other
// reset: synchronous, active low; addresses and indexes clear, wraps go to all ones;
//   busy is high during reset and drops in the first cycle after it
// the receiver cannot stall: every result is shown exactly once and then dropped
module dsp_wrapping_address_unit #(
  parameter int unsigned NUM_SETS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  in_operation,
  input  logic [1:0]                  in_reg_sel,
  input  logic [1:0]                  in_index_sel,
  input  logic [dwau_pkg::ADDR_W-1:0] in_write_value,
  output logic                        out_valid,
  output logic [dwau_pkg::ADDR_W-1:0] out_address_out
);
  import dwau_pkg::*;

  localparam int unsigned SET_W = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;

  // input register
  logic              busy_r;
  logic              vld_r;
  logic [2:0]        op_r;
  logic [1:0]        rs_r;
  logic [1:0]        is_r;
  logic [ADDR_W-1:0] val_r;

  // register file
  logic [ADDR_W-1:0] addr_r  [NUM_SETS];
  logic [ADDR_W-1:0] wrap_r  [NUM_SETS];
  logic [ADDR_W-1:0] index_r [NUM_SETS];

  // result register
  logic              out_vld_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [ADDR_W-1:0] out_addr_nxt;

  op_t               op;
  logic              rs_ok;
  logic              is_ok;
  logic [SET_W-1:0]  rs_idx;
  logic [SET_W-1:0]  is_idx;
  logic [SET_W-1:0]  ix_idx;
  logic [ADDR_W-1:0] addr_cur;
  logic [ADDR_W-1:0] wrap_cur;
  logic [ADDR_W-1:0] index_cur;
  logic [ADDR_W-1:0] step_addr;
  logic [ADDR_W-1:0] addr_nxt;
  logic              addr_we;
  logic              wrap_we;
  logic              index_we;

  assign busy = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= 1'b0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= start & ~busy_r;
    end
  end

  // payload capture, no reset needed
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      op_r  <= in_operation;
      rs_r  <= in_reg_sel;
      is_r  <= in_index_sel;
      val_r <= in_write_value;
    end
  end

  assign op     = op_t'(op_r);
  assign rs_ok  = ({30'd0, rs_r} < NUM_SETS);
  assign is_ok  = ({30'd0, is_r} < NUM_SETS);
  assign rs_idx = SET_W'(rs_r);
  assign is_idx = SET_W'(is_r);

  // add index reads the index_sel set, subtract reads the reg_sel set
  assign ix_idx = (op == OP_ADD_INDEX) ? is_idx : rs_idx;

  assign addr_cur  = addr_r[rs_idx];
  assign wrap_cur  = wrap_r[rs_idx];
  assign index_cur = index_r[ix_idx];

  dwau_step u_step (
    .addr_op   (op),
    .addr_cur  (addr_cur),
    .wrap_cur  (wrap_cur),
    .index_cur (index_cur),
    .addr_new  (step_addr)
  );

  // decode writes and the new address of the selected set
  always_comb begin
    addr_we  = 1'b0;
    wrap_we  = 1'b0;
    index_we = 1'b0;
    addr_nxt = addr_cur;
    unique case (op)
      OP_WR_ADDR: begin
        addr_we  = 1'b1;
        addr_nxt = val_r;
      end
      OP_WR_WRAP:  wrap_we  = 1'b1;
      OP_WR_INDEX: index_we = 1'b1;
      OP_INC, OP_DEC, OP_SUB_INDEX: begin
        addr_we  = 1'b1;
        addr_nxt = step_addr;
      end
      OP_ADD_INDEX: begin
        // an index set beyond the register file leaves the address alone
        if (is_ok) begin
          addr_we  = 1'b1;
          addr_nxt = step_addr;
        end
      end
      default: ;
    endcase
  end

  assign out_addr_nxt = rs_ok ? addr_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SETS; i++) begin
        addr_r[i]  <= '0;
        wrap_r[i]  <= '1;
        index_r[i] <= '0;
      end
    end else if (vld_r && rs_ok) begin
      if (addr_we) begin
        addr_r[rs_idx] <= addr_nxt;
      end
      if (wrap_we) begin
        wrap_r[rs_idx] <= val_r;
      end
      if (index_we) begin
        index_r[rs_idx] <= val_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (vld_r) begin
      out_addr_r <= out_addr_nxt;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_address_out = out_addr_r;

endmodule

// ===== hw/rtl/dwau_step.sv =====
module dwau_step (
  input  dwau_pkg::op_t                addr_op,
  input  logic [dwau_pkg::ADDR_W-1:0]  addr_cur,
  input  logic [dwau_pkg::ADDR_W-1:0]  wrap_cur,
  input  logic [dwau_pkg::ADDR_W-1:0]  index_cur,
  output logic [dwau_pkg::ADDR_W-1:0]  addr_new
);
  import dwau_pkg::*;

  logic [WIDE_W-1:0] a_w;
  logic [WIDE_W-1:0] w_w;
  logic [WIDE_W-1:0] w_p1;
  logic [WIDE_W-1:0] top;
  logic [WIDE_W-1:0] ix_ext;
  logic [WIDE_W-1:0] ix_inv;
  logic [WIDE_W-1:0] inc_sum;
  logic [WIDE_W-1:0] inc_res;
  logic [WIDE_W-1:0] dec_sum;
  logic [WIDE_W-1:0] dec_res;
  logic [WIDE_W-1:0] ix_opnd;
  logic              ix_cin;
  logic              ix_up;
  logic [WIDE_W-1:0] ix_sum;
  logic [WIDE_W-1:0] ix_dif;
  logic [WIDE_W-1:0] ix_hi;
  logic [WIDE_W-1:0] ix_res;

  assign a_w    = {1'b0, addr_cur};
  assign w_w    = {1'b0, wrap_cur};
  assign w_p1   = w_w + WIDE_W'(1);
  assign top    = top_bit(wrap_cur);
  assign ix_ext = {index_cur[ADDR_W-1], index_cur};
  assign ix_inv = ~ix_ext;

  // increment: step up by one, fold back when leaving the window
  assign inc_sum = a_w + WIDE_W'(1);
  assign inc_res = ((inc_sum ^ a_w) > top) ? (inc_sum - w_p1) : inc_sum;

  // decrement: add wrap, fold back on carry into the top bit
  assign dec_sum = a_w + w_w;
  assign dec_res = (((dec_sum ^ a_w) & top) > w_w) ? (dec_sum - w_p1) : dec_sum;

  // indexed steps share one adder; subtract adds the inverted index plus one
  always_comb begin
    if (addr_op == OP_SUB_INDEX) begin
      ix_opnd = ix_inv;
      ix_cin  = 1'b1;
      ix_up   = (ix_inv < SUB_SPLIT);
    end else begin
      ix_opnd = ix_ext;
      ix_cin  = 1'b0;
      ix_up   = ~index_cur[ADDR_W-1];
    end
  end

  assign ix_sum = a_w + ix_opnd + WIDE_W'(ix_cin);
  assign ix_dif = (ix_sum ^ a_w ^ ix_opnd) & top;
  assign ix_hi  = ix_sum + w_p1;

  always_comb begin
    if (ix_up) begin
      ix_res = (ix_dif > w_w) ? (ix_sum - w_p1) : ix_sum;
    end else begin
      ix_res = (((ix_hi ^ ix_sum) & ix_dif) <= w_w) ? ix_hi : ix_sum;
    end
  end

  always_comb begin
    unique case (addr_op)
      OP_INC:                     addr_new = inc_res[ADDR_W-1:0];
      OP_DEC:                     addr_new = dec_res[ADDR_W-1:0];
      OP_ADD_INDEX, OP_SUB_INDEX: addr_new = ix_res[ADDR_W-1:0];
      default:                    addr_new = addr_cur;
    endcase
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

// self-checking bench for the circular address generation unit
//
// every accepted transaction is run through a shadow copy of the four register
// sets; the address it predicts is queued and compared with the next strobed
// result. directed tasks cover the window edges and every step, then a long
// random stretch mixes register writes with steps on power-of-two and arbitrary windows
module testbench;
  import dwau_pkg::*;

  localparam int unsigned SET_COUNT      = 4;
  // code with no operation behind it: leaves the registers alone
  localparam logic [2:0]  OP_UNUSED      = 3'd7;
  // inverted index below this picks the upward check for subtract
  localparam logic [31:0] SUB_UP_LIMIT   = 32'h0000_7FFF;
  localparam int unsigned RESULT_LATENCY = 2;
  localparam int unsigned WATCHDOG_LIMIT = 200;
  localparam int unsigned RANDOM_ITEMS   = 950;
  localparam int unsigned REPORT_LIMIT   = 10;

  typedef struct {
    logic [2:0]        op;
    logic [1:0]        reg_set;
    logic [ADDR_W-1:0] address;
  } address_expect_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_operation;
  logic [1:0]        in_reg_sel;
  logic [1:0]        in_index_sel;
  logic [ADDR_W-1:0] in_write_value;
  logic              out_valid;
  logic [ADDR_W-1:0] out_address_out;

  // shadow register file, updated at each accepted transaction
  logic [ADDR_W-1:0] shadow_address [0:3];
  logic [ADDR_W-1:0] shadow_wrap    [0:3];
  logic [ADDR_W-1:0] shadow_index   [0:3];

  address_expect_t expected_addresses [$];
  int              mismatch_count;
  int unsigned     idle_cycles;
  int unsigned     burst_left;

  dsp_wrapping_address_unit #(
    .NUM_SETS(SET_COUNT)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_reg_sel     (in_reg_sel),
    .in_index_sel   (in_index_sel),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_address_out(out_address_out)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // indexed step shared by add and subtract; sums are 32 bits wide like the
  // carry-difference checks expect, the window top bit is (wrap | 1) << 1
  function automatic logic [ADDR_W-1:0] indexed_wrap(input logic [31:0] base,
                                                     input logic [31:0] wrap,
                                                     input logic [31:0] stride,
                                                     input logic        carry_in,
                                                     input logic        upward);
    logic [31:0] sum;
    logic [31:0] crossed;
    logic [31:0] carry_bit;
    carry_bit = (wrap | 32'd1) << 1;
    sum       = base + stride + {31'd0, carry_in};
    crossed   = (sum ^ base ^ stride) & carry_bit;
    if (upward) begin
      // only overflow past the top of the window can happen
      if (crossed > wrap) sum = sum - wrap - 32'd1;
    end else if ((((sum + wrap + 32'd1) ^ sum) & crossed) <= wrap) begin
      // went below the bottom of the window
      sum = sum + wrap + 32'd1;
    end
    return sum[ADDR_W-1:0];
  endfunction

  // applies one transaction to the shadow registers, returns the new address
  function automatic logic [ADDR_W-1:0] step_address(input logic [2:0]        op,
                                                     input logic [1:0]        reg_set,
                                                     input logic [1:0]        index_set,
                                                     input logic [ADDR_W-1:0] value);
    logic [31:0] base;
    logic [31:0] wrap;
    logic [31:0] sum;
    logic [31:0] carry_bit;
    logic [31:0] index_ext;
    if (reg_set >= SET_COUNT) return '0;
    base      = {16'd0, shadow_address[reg_set]};
    wrap      = {16'd0, shadow_wrap[reg_set]};
    carry_bit = (wrap | 32'd1) << 1;
    case (op)
      OP_WR_ADDR:  shadow_address[reg_set] = value;
      OP_WR_WRAP:  shadow_wrap[reg_set] = value;
      OP_WR_INDEX: shadow_index[reg_set] = value;
      OP_INC: begin
        sum = base + 32'd1;
        if ((sum ^ base) > carry_bit) sum = sum - wrap - 32'd1;
        shadow_address[reg_set] = sum[ADDR_W-1:0];
      end
      OP_DEC: begin
        // adding the wrap value steps back by one inside the window
        sum = base + wrap;
        if (((sum ^ base) & carry_bit) > wrap) sum = sum - wrap - 32'd1;
        shadow_address[reg_set] = sum[ADDR_W-1:0];
      end
      OP_ADD_INDEX: begin
        // index comes from index_sel; direction from its sign
        if (index_set < SET_COUNT) begin
          index_ext = {{16{shadow_index[index_set][15]}}, shadow_index[index_set]};
          shadow_address[reg_set] = indexed_wrap(base, wrap, index_ext, 1'b0,
                                                 ~index_ext[31]);
        end
      end
      OP_SUB_INDEX: begin
        // subtract always uses the index of its own set: a + ~ix + 1
        index_ext = ~{{16{shadow_index[reg_set][15]}}, shadow_index[reg_set]};
        shadow_address[reg_set] = indexed_wrap(base, wrap, index_ext, 1'b1,
                                               index_ext < SUB_UP_LIMIT);
      end
      default: ;
    endcase
    return shadow_address[reg_set];
  endfunction

  // monitor: checks the strobed result first, then records the transaction
  // accepted at this edge; both in one block so the order is fixed
  always @(posedge clk) begin
    address_expect_t due;
    address_expect_t fresh;
    logic            active;
    active = 1'b0;
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        shadow_address[i] = '0;
        shadow_wrap[i]    = '1;
        shadow_index[i]   = '0;
      end
    end else begin
      if (out_valid === 1'b1) begin
        active = 1'b1;
        if (expected_addresses.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: result %h with no transaction pending", $time, out_address_out);
        end else begin
          due = expected_addresses.pop_front();
          if (out_address_out !== due.address) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
              $display("%0t: op %0d set %0d address expected %h got %h", $time,
                       due.op, due.reg_set, due.address, out_address_out);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        active          = 1'b1;
        fresh.op        = in_operation;
        fresh.reg_set   = in_reg_sel;
        fresh.address   = step_address(in_operation, in_reg_sel, in_index_sel,
                                       in_write_value);
        expected_addresses.push_back(fresh);
      end
    end
    // watchdog: too long without any transaction or result
    if (active) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL dsp_wrapping_address_unit");
      $finish;
    end
  end

  // drives one transaction, holds it until taken, then paces the sender in
  // bursts with random gaps between them
  task automatic send_item(input logic [2:0]        op,
                           input logic [1:0]        reg_set,
                           input logic [1:0]        index_set,
                           input logic [ADDR_W-1:0] value);
    int unsigned gap;
    @(negedge clk);
    start          <= 1'b1;
    in_operation   <= op;
    in_reg_sel     <= reg_set;
    in_index_sel   <= index_set;
    in_write_value <= value;
    do @(posedge clk); while (busy !== 1'b0);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) < 6) gap = $urandom_range(0, 3);
      else if ($urandom_range(0, 9) < 8) gap = $urandom_range(4, 8);
      else gap = $urandom_range(9, 20);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      // now and then a long back-to-back stretch
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(30, 80);
      else burst_left = $urandom_range(1, 12);
    end
  endtask

  // extremes of every register on several sets
  task automatic test_register_writes;
    send_item(OP_WR_ADDR,  2'd1, 2'd0, 16'hFFFF);
    send_item(OP_WR_WRAP,  2'd2, 2'd0, 16'h0000);
    send_item(OP_WR_INDEX, 2'd1, 2'd0, 16'h8000);
    send_item(OP_WR_INDEX, 2'd3, 2'd0, 16'h7FFF);
    send_item(OP_WR_WRAP,  2'd3, 2'd3, 16'hFFFF);
  endtask

  // full-range rollover, then a 16-entry window wrapping at its top
  task automatic test_increment;
    send_item(OP_WR_ADDR, 2'd0, 2'd0, 16'hFFFF);
    send_item(OP_INC,     2'd0, 2'd0, 16'h0000);
    send_item(OP_WR_WRAP, 2'd0, 2'd0, 16'h000F);
    send_item(OP_WR_ADDR, 2'd0, 2'd0, 16'h001F);
    send_item(OP_INC,     2'd0, 2'd3, 16'hFFFF);
  endtask

  // window bottom back to its top, and a zero-wide window
  task automatic test_decrement;
    send_item(OP_DEC, 2'd0, 2'd0, 16'h0000);
    send_item(OP_DEC, 2'd0, 2'd1, 16'h0000);
    send_item(OP_DEC, 2'd2, 2'd0, 16'h0000);
  endtask

  // most negative, most positive, small and zero index from several sets
  task automatic test_add_index;
    send_item(OP_ADD_INDEX, 2'd0, 2'd1, 16'h0000);
    send_item(OP_ADD_INDEX, 2'd0, 2'd3, 16'h0000);
    send_item(OP_WR_INDEX,  2'd2, 2'd0, 16'hFFFB);
    send_item(OP_ADD_INDEX, 2'd0, 2'd2, 16'h0000);
    send_item(OP_ADD_INDEX, 2'd0, 2'd0, 16'h0000);
  endtask

  // negative index, the most negative index and a positive one
  task automatic test_sub_index;
    send_item(OP_WR_INDEX,  2'd0, 2'd0, 16'hFFFF);
    send_item(OP_SUB_INDEX, 2'd0, 2'd0, 16'h0000);
    send_item(OP_SUB_INDEX, 2'd1, 2'd0, 16'h0000);
    send_item(OP_SUB_INDEX, 2'd3, 2'd0, 16'h0000);
  endtask

  // code without an operation just reports the address
  task automatic test_unused_operation;
    send_item(OP_UNUSED, 2'd0, 2'd2, 16'hFFFF);
    send_item(OP_UNUSED, 2'd3, 2'd1, 16'h0000);
  endtask

  // mostly steps on power-of-two windows, with writes mixed in
  task automatic test_random_traffic;
    logic [2:0]        op;
    logic [1:0]        reg_set;
    logic [1:0]        index_set;
    logic [ADDR_W-1:0] value;
    int unsigned       pick;
    int unsigned       width;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      reg_set   = 2'($urandom_range(0, 3));
      index_set = 2'($urandom_range(0, 3));
      value     = 16'($urandom);
      pick      = $urandom_range(0, 99);
      if (pick < 10) begin
        op = OP_WR_WRAP;
        if ($urandom_range(0, 9) < 7) begin
          width = $urandom_range(0, 16);
          value = 16'((32'd1 << width) - 32'd1);
        end
      end else if (pick < 20) begin
        op = OP_WR_ADDR;
      end else if (pick < 30) begin
        op = OP_WR_INDEX;
        case ($urandom_range(0, 3))
          0: ;
          1: value = 16'($urandom_range(0, 32)) - 16'd16;
          2: begin
            case ($urandom_range(0, 3))
              0: value = 16'h8000;
              1: value = 16'h7FFF;
              2: value = 16'hFFFF;
              default: value = 16'h0001;
            endcase
          end
          default: begin
            // stride that fits the window, either sign
            value = value & shadow_wrap[reg_set];
            if ($urandom_range(0, 1) == 1) value = -value;
          end
        endcase
      end else if (pick < 95) begin
        case ($urandom_range(0, 3))
          0: op = OP_INC;
          1: op = OP_DEC;
          2: op = OP_ADD_INDEX;
          default: op = OP_SUB_INDEX;
        endcase
      end else begin
        op = OP_UNUSED;
      end
      send_item(op, reg_set, index_set, value);
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_operation   = OP_WR_ADDR;
    in_reg_sel     = 2'd0;
    in_index_sel   = 2'd0;
    in_write_value = '0;
    mismatch_count = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_register_writes();
    test_increment();
    test_decrement();
    test_add_index();
    test_sub_index();
    test_unused_operation();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    // drain; the watchdog ends the run if a result never shows up
    while (expected_addresses.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS dsp_wrapping_address_unit");
    end else begin
      $display("FAIL dsp_wrapping_address_unit");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/dwau_pkg.sv
hw/rtl/dwau_step.sv
hw/rtl/dsp_wrapping_address_unit.sv
test/testbench.sv
